FILE: hw/rtl/tdv_pkg.sv
// Package for the time-of-day token validator.
// Holds widths, character codes, register indexes and shared types.
// No dependencies.
package tdv_pkg;

    // Field and state widths.
    localparam int CHAR_W     = 8;
    localparam int FIELD_W    = 7;
    localparam int RUN_W      = 2;
    localparam int SEP_W      = 2;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int PROD_W     = 11;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

    // Token format.
    localparam logic [RUN_W-1:0] DIGITS_PER_FIELD = 2'd2;
    localparam logic [SEP_W-1:0] LAST_SEPARATOR   = 2'd2;
    localparam logic [3:0]       RADIX            = 4'd10;
    localparam logic [FIELD_W-1:0] FIELD_MAX      = 7'd99;

    // Register reset values.
    localparam logic [FIELD_W-1:0] HOUR_LIMIT_RST  = 7'd23;
    localparam logic [FIELD_W-1:0] FIELD_LIMIT_RST = 7'd59;

    // Saturation point of the valid token count.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOUR_LIMIT  = 1'b0,
        CFG_FIELD_LIMIT = 1'b1
    } t_cfg_idx;

    // One configuration write.
    typedef struct packed {
        logic                  we;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_write;

    // One result item.
    typedef struct packed {
        logic               token_valid;
        logic [COUNT_W-1:0] valid_count;
    } t_result;

endpackage

FILE: hw/rtl/tdv_char_if.sv
// Character channel of the time-of-day token validator.
// Carries valid, ready and one character with its end-of-token flag.
// Depends on tdv_pkg.
interface tdv_char_if
    import tdv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_of_token;

    modport source (output valid, output char_code, output last_of_token, input ready);
    modport sink   (input valid, input char_code, input last_of_token, output ready);
endinterface

FILE: hw/rtl/tdv_result_if.sv
// Result channel of the time-of-day token validator.
// Carries valid, ready, the token verdict and the valid token count.
// Depends on tdv_pkg.
interface tdv_result_if
    import tdv_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               token_valid;
    logic [COUNT_W-1:0] valid_count;

    modport source (output valid, output token_valid, output valid_count, input ready);
    modport sink   (input valid, input token_valid, input valid_count, output ready);
endinterface

FILE: hw/rtl/tdv_parser.sv
// Token parser: limit registers, per-token state and the valid token count.
// Updates the state on each character transfer and produces a result on the last one.
// Depends on tdv_pkg.
module tdv_parser
    import tdv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg_write        i_cfg,
    input  logic              i_take,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_last_of_token,
    output logic              o_push,
    output t_result           o_result
);

    logic [FIELD_W-1:0] r_hour_limit;
    logic [FIELD_W-1:0] r_field_limit;
    logic [RUN_W-1:0]   r_digit_run,   n_digit_run;
    logic [SEP_W-1:0]   r_sep_count,   n_sep_count;
    logic [FIELD_W-1:0] r_field_value, n_field_value;
    logic               r_token_bad,   n_token_bad;
    logic [COUNT_W-1:0] r_good_tokens, n_good_tokens;

    logic              w_is_digit;
    logic              w_is_colon;
    logic [PROD_W-1:0] w_value;
    logic [FIELD_W-1:0] w_limit;
    logic              w_ok;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_limit  <= HOUR_LIMIT_RST;
            r_field_limit <= FIELD_LIMIT_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_HOUR_LIMIT:  r_hour_limit  <= i_cfg.data;
                CFG_FIELD_LIMIT: r_field_limit <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Character classification and the running field value.
    assign w_is_digit = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);
    assign w_is_colon = (i_char_code == CHAR_COLON);
    assign w_value    = (PROD_W'(r_field_value) * PROD_W'(RADIX))
                      + PROD_W'(i_char_code[3:0]);
    assign w_limit    = (r_sep_count == '0) ? r_hour_limit : r_field_limit;

    // Next token state for one character.
    always_comb begin
        n_digit_run   = r_digit_run;
        n_sep_count   = r_sep_count;
        n_field_value = r_field_value;
        n_token_bad   = r_token_bad;
        if (!r_token_bad) begin
            if (w_is_digit) begin
                if (r_digit_run >= DIGITS_PER_FIELD) begin
                    n_token_bad = 1'b1;
                end else if (w_value > PROD_W'(w_limit)) begin
                    n_token_bad = 1'b1;
                end else begin
                    n_field_value = w_value[FIELD_W-1:0];
                    n_digit_run   = r_digit_run + 1'b1;
                end
            end else if (w_is_colon) begin
                if (r_digit_run != DIGITS_PER_FIELD || r_sep_count >= LAST_SEPARATOR) begin
                    n_token_bad = 1'b1;
                end else begin
                    n_field_value = '0;
                    n_digit_run   = '0;
                    n_sep_count   = r_sep_count + 1'b1;
                end
            end else begin
                n_token_bad = 1'b1;
            end
        end
    end

    // Verdict and count at the end of a token.
    assign w_ok = !n_token_bad && (n_sep_count == LAST_SEPARATOR)
               && (n_digit_run == DIGITS_PER_FIELD);
    assign n_good_tokens = (w_ok && r_good_tokens != COUNT_MAX) ? r_good_tokens + 1'b1
                                                                : r_good_tokens;

    assign o_push               = i_take && i_last_of_token;
    assign o_result.token_valid = w_ok;
    assign o_result.valid_count = n_good_tokens;

    // Token state; cleared at each token end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_run   <= '0;
            r_sep_count   <= '0;
            r_field_value <= '0;
            r_token_bad   <= 1'b0;
            r_good_tokens <= '0;
        end else if (i_take) begin
            if (i_last_of_token) begin
                r_digit_run   <= '0;
                r_sep_count   <= '0;
                r_field_value <= '0;
                r_token_bad   <= 1'b0;
                r_good_tokens <= n_good_tokens;
            end else begin
                r_digit_run   <= n_digit_run;
                r_sep_count   <= n_sep_count;
                r_field_value <= n_field_value;
                r_token_bad   <= n_token_bad;
            end
        end
    end

    // The separator count never passes the last separator.
    a_sep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_sep_count <= LAST_SEPARATOR)
        else $error("separator count out of range");

    // A field never holds more than two digits or a value above 99.
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_digit_run <= DIGITS_PER_FIELD && r_field_value <= FIELD_MAX))
        else $error("field state out of range");

    // The valid token count never goes down.
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_good_tokens >= $past(r_good_tokens))
        else $error("valid token count decreased");

endmodule

FILE: hw/rtl/tdv_out_buf.sv
// Result register with a skid stage for the token validator.
// Lets a character transfer proceed while a finished result waits downstream.
// Depends on tdv_pkg.
module tdv_out_buf
    import tdv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    w_pop;

    assign w_pop   = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // Valid flags of the result and skid stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_pop) begin
                r_out_valid  <= r_skid_valid || i_push;
                r_skid_valid <= r_skid_valid && i_push;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload movement between the stages.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_push) begin
                r_out_data <= i_data;
            end
        end
        if (i_push && r_out_valid && !(w_pop && !r_skid_valid)) begin
            r_skid_data <= i_data;
        end
    end

    // The skid stage is only occupied behind a full result stage.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while result stage empty");

    // No result arrives while both stages are full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed into a full buffer");

    // A waiting skid entry moves up when the result stage is taken.
    a_skid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> r_out_valid)
        else $error("skid entry lost");

endmodule

FILE: hw/rtl/time_of_day_token_validator_core.sv
// Time-of-day token validator, top level.
// A token's result is registered in the result buffer on the transfer of its last character.
// Throughput: one character per cycle while the result buffer has room, set by the token state update.
// A two-entry result buffer keeps characters flowing while one result waits downstream.
// Reset (synchronous, active low) clears the token state and the count, sets limits 23 and 59.
// Depends on tdv_pkg, tdv_char_if, tdv_result_if, tdv_parser and tdv_out_buf.
module time_of_day_token_validator_core
    import tdv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tdv_char_if.sink              i_char,
    tdv_result_if.source          o_result
);

    t_cfg_write w_cfg;
    logic       w_space;
    logic       w_take;
    logic       w_push;
    t_result    w_result;
    t_result    w_out_data;

    // Configuration write bundle.
    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = t_cfg_idx'(i_cfg_idx);
    assign w_cfg.data = i_cfg_data;

    // A character transfers whenever the result buffer has room.
    assign i_char.ready = w_space;
    assign w_take       = i_char.valid && w_space;

    tdv_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_take          (w_take),
        .i_char_code     (i_char.char_code),
        .i_last_of_token (i_char.last_of_token),
        .o_push          (w_push),
        .o_result        (w_result)
    );

    tdv_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_space (w_space),
        .o_valid (o_result.valid),
        .o_data  (w_out_data),
        .i_ready (o_result.ready)
    );

    // Result channel payload.
    assign o_result.token_valid = w_out_data.token_valid;
    assign o_result.valid_count = w_out_data.valid_count;

endmodule

FILE: tb/time_of_day_token_validator_core_test.sv
// Self-checking testbench for the time-of-day token validator core.
// Streams character tokens, predicts each verdict and count, and checks every result transfer.
// Depends on tdv_pkg, tdv_char_if, tdv_result_if and time_of_day_token_validator_core.
module time_of_day_token_validator_core_test
    import tdv_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_CHARS   = 325;
    localparam int NUM_PHASES    = 6;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_item;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tdv_char_if   char_ch ();
    tdv_result_if res_ch ();

    // Characters waiting to be driven and verdicts waiting to be seen.
    t_char_item        pending_chars[$];
    t_result           expected_verdicts[$];
    logic [CHAR_W-1:0] draft[$];

    // Predicted token state and limits.
    logic [RUN_W-1:0]   digits_seen;
    logic [SEP_W-1:0]   colons_seen;
    logic [FIELD_W-1:0] field_acc;
    logic               token_failed;
    logic [COUNT_W-1:0] good_total;
    logic [FIELD_W-1:0] hour_lim;
    logic [FIELD_W-1:0] fld_lim;

    int   send_idle_pct = 26;
    int   recv_idle_pct = 64;
    logic char_taken    = 1'b0;
    int   quiet_cycles  = 0;
    int   error_count   = 0;
    int   tokens_checked = 0;
    int   chars_sent    = 0;

    time_of_day_token_validator_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_char     (char_ch),
        .o_result   (res_ch)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Update the predicted token state with one character; a last character yields a verdict.
    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last);
        int unsigned acc;
        logic        ok;
        t_result     verdict;
        if (!token_failed) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                acc = field_acc * RADIX + (c - CHAR_ZERO);
                if (digits_seen >= DIGITS_PER_FIELD) begin
                    token_failed = 1'b1;
                end else if (colons_seen == 0 ? acc > hour_lim : acc > fld_lim) begin
                    token_failed = 1'b1;
                end else begin
                    field_acc   = acc[FIELD_W-1:0];
                    digits_seen = digits_seen + 1'b1;
                end
            end else if (c == CHAR_COLON) begin
                if (digits_seen != DIGITS_PER_FIELD || colons_seen >= LAST_SEPARATOR) begin
                    token_failed = 1'b1;
                end else begin
                    field_acc   = '0;
                    digits_seen = '0;
                    colons_seen = colons_seen + 1'b1;
                end
            end else begin
                token_failed = 1'b1;
            end
        end
        if (last) begin
            ok = !token_failed && colons_seen == LAST_SEPARATOR
                 && digits_seen == DIGITS_PER_FIELD;
            if (ok && good_total != COUNT_MAX)
                good_total = good_total + 1'b1;
            verdict.token_valid = ok;
            verdict.valid_count = good_total;
            expected_verdicts.push_back(verdict);
            digits_seen  = '0;
            colons_seen  = '0;
            field_acc    = '0;
            token_failed = 1'b0;
        end
    endtask

    // Compare one result transfer against the oldest predicted verdict.
    task automatic check_verdict(input logic valid_bit, input logic [COUNT_W-1:0] count);
        t_result want;
        if (expected_verdicts.size() == 0) begin
            $display("%0t: result with none expected (token_valid %0b, valid_count %0d)",
                     $time, valid_bit, count);
            error_count++;
        end else begin
            want = expected_verdicts.pop_front();
            tokens_checked++;
            if (valid_bit !== want.token_valid) begin
                $display("%0t: token_valid expected %0b, got %0b",
                         $time, want.token_valid, valid_bit);
                error_count++;
            end
            if (count !== want.valid_count) begin
                $display("%0t: valid_count expected %0d, got %0d",
                         $time, want.valid_count, count);
                error_count++;
            end
        end
    endtask

    // Sample both channels at the rising edge; the watchdog counts edges without a transfer.
    always @(posedge i_clk) begin
        char_taken = 1'b0;
        if (i_rst_n) begin
            char_taken = char_ch.valid && char_ch.ready;
            if (char_taken) begin
                chars_sent++;
                parse_char(char_ch.char_code, char_ch.last_of_token);
            end
            if (res_ch.valid && res_ch.ready)
                check_verdict(res_ch.token_valid, res_ch.valid_count);
            if (char_taken || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Character driver and result back-pressure, both updated at the falling edge.
    always @(negedge i_clk) begin
        t_char_item nxt;
        if (i_rst_n) begin
            if (!char_ch.valid || char_taken) begin
                if (pending_chars.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_chars.pop_front();
                    char_ch.valid         <= 1'b1;
                    char_ch.char_code     <= nxt.code;
                    char_ch.last_of_token <= nxt.last;
                end else begin
                    char_ch.valid <= 1'b0;
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Move the drafted token into the send queue, flagging its final character.
    task automatic queue_draft();
        t_char_item item;
        foreach (draft[i]) begin
            item.code = draft[i];
            item.last = (i == draft.size() - 1);
            pending_chars.push_back(item);
        end
        draft.delete();
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
        queue_draft();
    endtask

    task automatic draft_field(input int v);
        draft.push_back(CHAR_W'(CHAR_ZERO + v / RADIX));
        draft.push_back(CHAR_W'(CHAR_ZERO + v % RADIX));
    endtask

    // Field values lie mostly within the limit, often on or just above it, with some spread over the full range.
    function automatic int pick_value(input int lim);
        int cap;
        cap = (lim > FIELD_MAX) ? FIELD_MAX : lim;
        case ($urandom_range(0, 7))
            0:       return cap;
            1:       return (cap < FIELD_MAX) ? cap + 1 : cap;
            7:       return $urandom_range(0, FIELD_MAX);
            default: return $urandom_range(0, cap);
        endcase
    endfunction

    // Draft a well-formed time, then damage it in one of several ways some of the time.
    task automatic draft_random_token();
        int k;
        draft.delete();
        draft_field(pick_value(hour_lim));
        draft.push_back(CHAR_COLON);
        draft_field(pick_value(fld_lim));
        draft.push_back(CHAR_COLON);
        draft_field(pick_value(fld_lim));
        case ($urandom_range(0, 19))
            // A missing digit or a missing separator.
            0: draft.delete($urandom_range(0, draft.size() - 1));
            // A third digit in some field.
            1: draft.insert($urandom_range(0, draft.size()),
                            CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)));
            // Any byte in place of one character.
            2: draft[$urandom_range(0, draft.size() - 1)] = CHAR_W'($urandom_range(0, 255));
            // A third colon and a fourth field.
            3: begin
                draft.push_back(CHAR_COLON);
                draft_field(pick_value(fld_lim));
            end
            // A token cut short.
            4: draft = draft[0:$urandom_range(0, 6)];
            // A zero byte somewhere in the token.
            5: draft[$urandom_range(0, draft.size() - 1)] = 8'h00;
            // A leading colon.
            6: draft.push_front(CHAR_COLON);
            // Short runs of digits, colons and arbitrary bytes.
            7: begin
                draft.delete();
                repeat ($urandom_range(1, 10)) begin
                    k = $urandom_range(0, 3);
                    if (k == 0)
                        draft.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)));
                    else if (k == 1)
                        draft.push_back(CHAR_COLON);
                    else
                        draft.push_back(CHAR_W'($urandom_range(0, 255)));
                end
            end
            default: ;
        endcase
    endtask

    // Wait until nothing is in flight, then give the core time to settle.
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pending_chars.size() != 0 || char_ch.valid || expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HOUR_LIMIT:  hour_lim = data;
            CFG_FIELD_LIMIT: fld_lim  = data;
            default: ;
        endcase
    endtask

    // Stimulus: directed tokens, then six phases of random tokens under different limits.
    initial begin
        int hour_set[NUM_PHASES];
        int field_set[NUM_PHASES];
        int chars;

        hour_set  = '{23, 0, 99, 12, 0, 23};
        field_set = '{59, 0, 99, 30, 0, 59};
        hour_set[4]  = $urandom_range(0, FIELD_MAX);
        field_set[4] = $urandom_range(0, FIELD_MAX);

        char_ch.valid         = 1'b0;
        char_ch.char_code     = '0;
        char_ch.last_of_token = 1'b0;
        res_ch.ready          = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = CFG_HOUR_LIMIT;
        cfg_data              = '0;
        digits_seen           = '0;
        colons_seen           = '0;
        field_acc             = '0;
        token_failed          = 1'b0;
        good_total            = '0;
        hour_lim              = HOUR_LIMIT_RST;
        fld_lim               = FIELD_LIMIT_RST;

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Every expected result must arrive before the limits change.
            wait_idle();
            if (ph < 2) begin
                send_idle_pct = 26;
                recv_idle_pct = 64;
            end else if (ph < 4) begin
                send_idle_pct = 64;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_HOUR_LIMIT, CFG_DATA_W'(hour_set[ph]));
            write_reg(CFG_FIELD_LIMIT, CFG_DATA_W'(field_set[ph]));

            if (ph == 0) begin
                // Valid at both limits, hour over its limit, zero and top bytes,
                // a lone colon, a one-digit last field, and a digit after a failure.
                queue_text("23:59:59");
                queue_text("24");
                draft.push_back(8'h00);
                queue_draft();
                draft.push_back(8'hFF);
                queue_draft();
                queue_text(":");
                queue_text("00:00:0");
                queue_text("a5");
            end

            chars = 0;
            while (chars < PHASE_CHARS) begin
                draft_random_token();
                chars += draft.size();
                queue_draft();
            end
        end

        wait_idle();
        $display("Checked %0d tokens (%0d characters) under six limit settings,",
                 tokens_checked, chars_sent);
        $display("with damaged tokens and stalls on both sides.");
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", error_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
